// ----- rtl/multi_channel_tick_timer_bank_top_macros.svh -----
// Assertion macros for the tick timer bank.
`ifndef MULTI_CHANNEL_TICK_TIMER_BANK_TOP_MACROS_SVH
`define MULTI_CHANNEL_TICK_TIMER_BANK_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MCTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mctb_pkg.sv -----
// Types and constants shared by the tick timer bank modules.
package mctb_pkg;

	localparam int ACT_W   = 3;
	localparam int IDX_W   = 3;
	localparam int CNT_W   = 32;
	localparam int FIRED_W = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK  = 3'd0,
		ACT_LOAD  = 3'd1,
		ACT_START = 3'd2,
		ACT_STOP  = 3'd3,
		ACT_DELAY = 3'd4
	} action_e;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] timer_index;
		logic [CNT_W-1:0] period_value;
		logic             timer_mode;
	} in_item_t;

	typedef struct packed {
		logic [FIRED_W-1:0] fired_mask;
		logic               delay_busy;
	} out_item_t;

	// Decoded command broadcast to every channel cell.
	typedef struct packed {
		logic             tick;
		logic             load;
		logic             start;
		logic             stop;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] value;
		logic             periodic;
	} cell_cmd_t;

endpackage

// ----- rtl/mctb_cell.sv -----
// One timer channel: period, count, mode and enable, plus its link in the fired-mask chain.
module mctb_cell #(
	parameter int IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mctb_pkg::cell_cmd_t          cmd,
	input  logic [mctb_pkg::FIRED_W-1:0] mask_in,
	output logic [mctb_pkg::FIRED_W-1:0] mask_out
);

	localparam bit IDX_OK = (IDX < (1 << mctb_pkg::IDX_W));
	localparam logic [mctb_pkg::IDX_W-1:0] IDX_CODE = mctb_pkg::IDX_W'(IDX);
	localparam logic [mctb_pkg::FIRED_W-1:0] MY_BIT =
		(IDX < mctb_pkg::FIRED_W) ? (mctb_pkg::FIRED_W'(1) << IDX) : '0;

	logic [mctb_pkg::CNT_W-1:0] reload_q;
	logic [mctb_pkg::CNT_W-1:0] count_q;
	logic                       periodic_q;
	logic                       en_q;

	logic                       hit;
	logic [mctb_pkg::CNT_W-1:0] count_dec;
	logic                       fire;

	assign hit       = IDX_OK && (cmd.idx == IDX_CODE);
	assign count_dec = count_q - mctb_pkg::CNT_W'(1);
	assign fire      = cmd.tick && en_q && (count_dec == '0);
	assign mask_out  = mask_in | (fire ? MY_BIT : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q   <= '0;
			count_q    <= '0;
			periodic_q <= 1'b0;
			en_q       <= 1'b0;
		end else begin
			if (cmd.tick && en_q) begin
				if (fire) begin
					if (periodic_q) begin
						count_q <= reload_q;
					end else begin
						count_q <= count_dec;
						en_q    <= 1'b0;
					end
				end else begin
					count_q <= count_dec;
				end
			end
			if (cmd.load && hit) begin
				reload_q   <= cmd.value;
				count_q    <= cmd.value;
				periodic_q <= cmd.periodic;
			end
			if (cmd.start && hit) begin
				en_q <= 1'b1;
			end
			if (cmd.stop && hit) begin
				en_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/multi_channel_tick_timer_bank_top.sv -----
// Top level of the tick timer bank: command decode, channel cell row, delay counter, output register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  in      | in_valid  | in_stall  | in_item  (action, index, value, mode)
//  out     | out_valid | out_stall | out_item (fired_mask, delay_busy)
//
// One item per cycle unless the input stalls: every channel cell and the delay
// counter update in the cycle an item is accepted; its result sits in the output
// register in the next cycle. The fired mask ripples through the cell row in the accept cycle.
// Reset clears all counters, periods, modes and enables.
// The input stalls only while a result is held and the output is stalled.
`include "multi_channel_tick_timer_bank_top_macros.svh"

module multi_channel_tick_timer_bank_top #(
	parameter int NUM_TIMERS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mctb_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mctb_pkg::out_item_t out_item
);

	logic                         accept;
	mctb_pkg::cell_cmd_t          cmd;
	logic [mctb_pkg::FIRED_W-1:0] mask_chain [NUM_TIMERS+1];

	logic [mctb_pkg::CNT_W-1:0] delay_count_q;
	logic                       delay_en_q;
	logic                       delay_en_nxt;
	logic [mctb_pkg::CNT_W-1:0] delay_dec;
	logic                       is_delay;

	logic                out_valid_q;
	mctb_pkg::out_item_t out_item_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd          = '0;
		cmd.idx      = in_item.timer_index;
		cmd.value    = in_item.period_value;
		cmd.periodic = in_item.timer_mode;
		is_delay     = 1'b0;
		if (accept) begin
			unique case (in_item.action)
				mctb_pkg::ACT_TICK:  cmd.tick  = 1'b1;
				mctb_pkg::ACT_LOAD:  cmd.load  = 1'b1;
				mctb_pkg::ACT_START: cmd.start = 1'b1;
				mctb_pkg::ACT_STOP:  cmd.stop  = 1'b1;
				mctb_pkg::ACT_DELAY: is_delay  = 1'b1;
				default: ;
			endcase
		end
	end

	assign mask_chain[0] = '0;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		mctb_cell #(
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.mask_in  (mask_chain[i]),
			.mask_out (mask_chain[i+1])
		);
	end

	assign delay_dec = delay_count_q - mctb_pkg::CNT_W'(1);

	always_comb begin
		delay_en_nxt = delay_en_q;
		if (is_delay) begin
			delay_en_nxt = 1'b1;
		end else if (cmd.tick && delay_en_q && (delay_dec == '0)) begin
			delay_en_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_count_q <= '0;
			delay_en_q    <= 1'b0;
		end else begin
			delay_en_q <= delay_en_nxt;
			if (is_delay) begin
				delay_count_q <= in_item.period_value;
			end else if (cmd.tick && delay_en_q) begin
				delay_count_q <= delay_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.fired_mask <= mask_chain[NUM_TIMERS];
			out_item_q.delay_busy <= delay_en_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`MCTB_ASSERT_NEXT(a_mask_only_on_tick, accept && (in_item.action != mctb_pkg::ACT_TICK), out_item.fired_mask == '0, "fired mask set on a non-tick item")
	`MCTB_ASSERT_NEXT(a_delay_start_busy, accept && (in_item.action == mctb_pkg::ACT_DELAY), out_item.delay_busy, "delay not busy after delay start")
	`MCTB_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted item produced no result")
	`MCTB_ASSERT_NOW(a_busy_matches_state, out_valid && !accept, out_item.delay_busy == delay_en_q, "held delay_busy disagrees with delay state")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the tick timer bank: queued directed and random items, in-order result checking.
module tb_top;
	import mctb_pkg::*;

	localparam int NT        = 5;
	localparam int N_RANDOM  = 1650;
	localparam int PHASE_LEN = 150;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	multi_channel_tick_timer_bank_top #(
		.NUM_TIMERS(NT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #6 clk = ~clk;

	// Timer bank state as predicted.
	logic [CNT_W-1:0] timer_reload [NT];
	logic [CNT_W-1:0] timer_count  [NT];
	logic             timer_periodic [NT];
	logic             timer_on     [NT];
	logic [CNT_W-1:0] dly_count;
	logic             dly_on;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int        issued     = 0;
	int        mismatches = 0;
	bit        taken      = 1'b0;

	function automatic out_item_t next_timer_result(in_item_t it);
		out_item_t          r;
		logic [FIRED_W-1:0] fired;
		bit                 idx_ok;
		fired  = '0;
		idx_ok = (it.timer_index < NT);
		case (it.action)
			ACT_TICK: begin
				if (dly_on) begin
					dly_count = dly_count - 1'b1;
					if (dly_count == '0)
						dly_on = 1'b0;
				end
				for (int ch = 0; ch < NT; ch++) begin
					if (timer_on[ch]) begin
						timer_count[ch] = timer_count[ch] - 1'b1;
						if (timer_count[ch] == '0) begin
							if (timer_periodic[ch])
								timer_count[ch] = timer_reload[ch];
							else
								timer_on[ch] = 1'b0;
							if (ch < FIRED_W)
								fired[ch] = 1'b1;
						end
					end
				end
			end
			ACT_LOAD: begin
				if (idx_ok) begin
					timer_reload[it.timer_index]   = it.period_value;
					timer_count[it.timer_index]    = it.period_value;
					timer_periodic[it.timer_index] = it.timer_mode;
				end
			end
			ACT_START: begin
				if (idx_ok)
					timer_on[it.timer_index] = 1'b1;
			end
			ACT_STOP: begin
				if (idx_ok)
					timer_on[it.timer_index] = 1'b0;
			end
			ACT_DELAY: begin
				dly_count = it.period_value;
				dly_on    = 1'b1;
			end
			default: ;
		endcase
		r.fired_mask = fired;
		r.delay_busy = dly_on;
		return r;
	endfunction

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	task automatic queue_item(logic [ACT_W-1:0] a, logic [IDX_W-1:0] ix,
			logic [CNT_W-1:0] v, logic m);
		in_item_t it;
		it.action       = a;
		it.timer_index  = ix;
		it.period_value = v;
		it.timer_mode   = m;
		pending_items.push_back(it);
	endtask

	task automatic note_mismatch(string what, out_item_t exp_r, out_item_t act_r);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): exp mask=%b busy=%b, got mask=%b busy=%b",
				what, exp_r.fired_mask, exp_r.delay_busy, act_r.fired_mask,
				act_r.delay_busy);
	endtask

	// Driver: new item at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		int phase;
		phase = (issued / PHASE_LEN) % 4;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || taken) begin
			if (pending_items.size() == 0 ||
					roll(phase == 1 ? 78 : (phase == 3 ? 6 : 0))) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_item  <= pending_items.pop_front();
				issued++;
			end
		end
		out_stall <= roll(phase == 2 ? 78 : (phase == 3 ? 6 : 0));
	end

	// Monitor and predictor at the rising edge.
	always @(posedge clk) begin
		out_item_t exp_r;
		taken = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected item", '0, out_item);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.fired_mask !== out_item.fired_mask ||
							exp_r.delay_busy !== out_item.delay_busy)
						note_mismatch("field", exp_r, out_item);
				end
			end
			if (in_valid && !in_stall) begin
				taken = 1'b1;
				expected_results.push_back(next_timer_result(in_item));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int               r;
		logic [ACT_W-1:0] a;
		logic [IDX_W-1:0] ix;
		logic [CNT_W-1:0] v;
		for (int ch = 0; ch < NT; ch++) begin
			timer_reload[ch]   = '0;
			timer_count[ch]    = '0;
			timer_periodic[ch] = 1'b0;
			timer_on[ch]       = 1'b0;
		end
		dly_count = '0;
		dly_on    = 1'b0;

		// directed: one-shot, periodic, zero wrap, full-scale, bad index, unused codes, delay
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);
		queue_item(ACT_LOAD,  3'd0, 32'd1, 1'b0);
		queue_item(ACT_START, 3'd0, 32'd0, 1'b0);
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);
		queue_item(ACT_TICK,  3'd0, 32'hFFFF_FFFF, 1'b1);
		queue_item(ACT_LOAD,  3'd1, 32'd2, 1'b1);
		queue_item(ACT_START, 3'd1, 32'd0, 1'b0);
		queue_item(ACT_LOAD,  3'd2, 32'd0, 1'b0);
		queue_item(ACT_START, 3'd2, 32'd0, 1'b0);
		queue_item(ACT_LOAD,  3'd3, 32'hFFFF_FFFF, 1'b1);
		queue_item(ACT_START, 3'd3, 32'd0, 1'b0);
		queue_item(ACT_LOAD,  3'd4, 32'd3, 1'b1);
		queue_item(ACT_START, 3'd4, 32'd0, 1'b0);
		queue_item(ACT_DELAY, 3'd0, 32'd0, 1'b0);
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);
		queue_item(ACT_DELAY, 3'd0, 32'd2, 1'b0);
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);
		queue_item(ACT_STOP,  3'd1, 32'd0, 1'b0);
		queue_item(ACT_LOAD,  3'd5, 32'd1, 1'b1);
		queue_item(ACT_START, 3'd6, 32'd0, 1'b0);
		queue_item(ACT_STOP,  3'd7, 32'hFFFF_FFFF, 1'b1);
		queue_item(3'd5,      3'd7, 32'hFFFF_FFFF, 1'b1);
		queue_item(3'd6,      3'd0, 32'd0, 1'b0);
		queue_item(3'd7,      3'd3, 32'hA5A5_5A5A, 1'b1);
		queue_item(ACT_TICK,  3'd0, 32'd0, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			r  = $urandom_range(99);
			ix = IDX_W'($urandom_range(0, NT - 1));
			v  = $urandom();
			if (r < 45)
				a = ACT_TICK;
			else if (r < 60)
				a = ACT_LOAD;
			else if (r < 72)
				a = ACT_START;
			else if (r < 78)
				a = ACT_STOP;
			else if (r < 86)
				a = ACT_DELAY;
			else if (r < 93)
				a = ACT_W'($urandom_range(5, 7));
			else begin
				a  = ACT_W'($urandom_range(1, 3));
				ix = IDX_W'($urandom_range(NT, 7));
			end
			if ((a == ACT_LOAD || a == ACT_DELAY) && roll(85))
				v = $urandom_range(0, 9);
			queue_item(a, ix, v, 1'($urandom_range(1)));
		end

		repeat (3) @(negedge clk);
		#2 arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0)
			note_mismatch("missing item", expected_results[0], '0);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
